// ===== src/ps2mt_pkg.sv =====
package ps2mt_pkg;

  // Width of the cursor position registers and of the clamp bounds.
  localparam int POS_BITS = 12;
  // Width of the signed sum of a position and a motion delta.
  localparam int SUM_BITS = POS_BITS + 2;
  localparam int CFG_ADDR_BITS = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_X = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_Y = CFG_ADDR_BITS'(1);

  localparam logic [POS_BITS-1:0] MAX_X_RESET = POS_BITS'(1023);
  localparam logic [POS_BITS-1:0] MAX_Y_RESET = POS_BITS'(767);

  // Header byte fields.
  localparam int SYNC_BIT  = 3;
  localparam int X_OVF_BIT = 6;
  localparam int Y_OVF_BIT = 7;
  localparam int BTN_BITS  = 3;

  // An overflowing axis moves by this magnitude.
  localparam logic signed [9:0] OVF_MAG = 10'sd255;

  typedef struct packed {
    logic       done;
    logic [7:0] header;
    logic [7:0] dx_byte;
    logic [7:0] dy_byte;
  } pkt_t;

  // Signed motion delta of one axis, with the overflow flag applied.
  function automatic logic signed [9:0] motion(input logic [7:0] b, input logic ovf);
    logic signed [9:0] d;
    d = 10'(signed'(b));
    if (ovf) begin
      d = b[7] ? -OVF_MAG : OVF_MAG;
    end
    return d;
  endfunction

  // Clamp a signed position to the range 0 .. lim.
  function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [SUM_BITS-1:0] v,
                                                    input logic [POS_BITS-1:0] lim);
    logic [POS_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > signed'({2'b00, lim})) begin
      r = lim;
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/ps2mt_byte_if.sv =====
interface ps2mt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/ps2mt_event_if.sv =====
interface ps2mt_event_if;
  import ps2mt_pkg::*;
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] cursor_x;
  logic [POS_BITS-1:0] cursor_y;
  logic [BTN_BITS-1:0] button_mask;

  modport source (output valid, output cursor_x, output cursor_y, output button_mask,
                  input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input button_mask,
                output ready);
endinterface

// ===== src/ps2mt_cfg_if.sv =====
interface ps2mt_cfg_if;
  import ps2mt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] index;
  logic [POS_BITS-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/ps2mt_framer.sv =====
module ps2mt_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output ps2mt_pkg::pkt_t   pkt
);
  import ps2mt_pkg::*;

  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_DX     = 2'd1;
  localparam logic [1:0] PHASE_DY     = 2'd2;

  logic [1:0] phase;
  logic [7:0] header;
  logic [7:0] dx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PHASE_HEADER;
      header  <= '0;
      dx_byte <= '0;
    end else if (accept) begin
      unique case (phase)
        PHASE_DX: begin
          dx_byte <= rx_byte;
          phase   <= PHASE_DY;
        end
        PHASE_DY: begin
          phase <= PHASE_HEADER;
        end
        default: begin
          // Bytes without the sync bit are dropped until a header turns up.
          if (rx_byte[SYNC_BIT]) begin
            header <= rx_byte;
            phase  <= PHASE_DX;
          end else begin
            phase <= PHASE_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    pkt.done    = accept && (phase == PHASE_DY);
    pkt.header  = header;
    pkt.dx_byte = dx_byte;
    pkt.dy_byte = rx_byte;
  end

endmodule

// ===== src/ps2mt_cursor.sv =====
module ps2mt_cursor (
  input  logic                          clk,
  input  logic                          rst,
  input  ps2mt_pkg::pkt_t               pkt,
  input  logic [ps2mt_pkg::POS_BITS-1:0] max_x,
  input  logic [ps2mt_pkg::POS_BITS-1:0] max_y,
  ps2mt_event_if.source                 evt
);
  import ps2mt_pkg::*;

  logic [POS_BITS-1:0]        pos_x;
  logic [POS_BITS-1:0]        pos_y;
  logic [POS_BITS-1:0]        pos_x_next;
  logic [POS_BITS-1:0]        pos_y_next;
  logic signed [SUM_BITS-1:0] sum_x;
  logic signed [SUM_BITS-1:0] sum_y;
  logic                       valid;
  logic [BTN_BITS-1:0]        buttons;

  always_comb begin
    sum_x = signed'({2'b00, pos_x}) + SUM_BITS'(motion(pkt.dx_byte, pkt.header[X_OVF_BIT]));
    // Screen Y runs downwards, so upward motion lowers the position.
    sum_y = signed'({2'b00, pos_y}) - SUM_BITS'(motion(pkt.dy_byte, pkt.header[Y_OVF_BIT]));
    pos_x_next = clamp_pos(sum_x, max_x);
    pos_y_next = clamp_pos(sum_y, max_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      valid <= 1'b0;
    end else if (pkt.done) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      valid <= 1'b1;
    end else if (evt.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.done) begin
      buttons <= pkt.header[BTN_BITS-1:0];
    end
  end

  assign evt.valid       = valid;
  assign evt.cursor_x    = pos_x;
  assign evt.cursor_y    = pos_y;
  assign evt.button_mask = buttons;

endmodule

// ===== src/ps2mt_cfg_regs.sv =====
module ps2mt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  ps2mt_cfg_if.sink                      cfg,
  output logic [ps2mt_pkg::POS_BITS-1:0] max_x,
  output logic [ps2mt_pkg::POS_BITS-1:0] max_y
);
  import ps2mt_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= MAX_X_RESET;
      max_y <= MAX_Y_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAX_X: max_x <= cfg.data;
        REG_MAX_Y: max_y <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/ps2_mouse_packet_tracker.sv =====
// PS/2 mouse packet tracker. Bytes from the mouse arrive on the rx channel one request at a
// time and are gathered into three-byte packets of header, X motion and Y motion. While the
// tracker waits for a header it drops every byte whose bit 3 is clear, which brings it back
// into step after a lost byte. The third byte of a packet produces one request on the evt
// channel carrying the new cursor position and the left, right and middle button bits; the
// first two bytes produce nothing. Motion bytes are signed, an overflow flag in the header
// replaces that axis's motion by plus or minus 255, X grows with rightward motion and Y
// shrinks with upward motion, and both positions are clamped to the range 0 up to the
// max_x and max_y registers (reset values 1023 and 767). Registers are written on the cfg
// channel, index 0 for max_x and 1 for max_y, other indexes being ignored; writes are
// always accepted and should only be made while no packet is in flight. The adder and clamp
// between the packet registers and the output register are the only work, so a byte can be
// accepted in every cycle unless input is stalled, including the cycle in which a waiting
// result is taken. The tracker stalls input only while a result sits in the output register
// and the sink is not ready.
module ps2_mouse_packet_tracker (
  input  logic          clk,
  input  logic          rst,
  ps2mt_byte_if.sink    rx,
  ps2mt_event_if.source evt,
  ps2mt_cfg_if.sink     cfg
);
  import ps2mt_pkg::*;

  logic                accept;
  pkt_t                pkt;
  logic [POS_BITS-1:0] max_x;
  logic [POS_BITS-1:0] max_y;

  // A byte may enter whenever the output register is empty or is being emptied this cycle.
  assign rx.ready = !evt.valid || evt.ready;
  assign accept   = rx.valid && rx.ready;

  ps2mt_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .max_x (max_x),
    .max_y (max_y)
  );

  ps2mt_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .pkt     (pkt)
  );

  ps2mt_cursor u_cursor (
    .clk   (clk),
    .rst   (rst),
    .pkt   (pkt),
    .max_x (max_x),
    .max_y (max_y),
    .evt   (evt)
  );

  // A new result must come from a byte accepted in the previous cycle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(evt.valid) |-> $past(accept))
    else $error("result appeared without an accepted byte");

  // A waiting result that is not taken blocks further input.
  assert property (@(posedge clk) disable iff (rst)
    (evt.valid && !evt.ready) |-> !rx.ready)
    else $error("input accepted while a result is stalled");

  // Reported positions never exceed the configured bounds.
  assert property (@(posedge clk) disable iff (rst)
    evt.valid |-> (evt.cursor_x <= max_x) && (evt.cursor_y <= max_y))
    else $error("cursor position beyond its bound");

endmodule
